/* rtl/cdq_pkg.sv */
// cdq_pkg: shared types and codes for the circular deque
// request codes, status codes, word widths and the control state type
// no dependencies
package cdq_pkg;

  localparam int FUNC_W   = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LIST       = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST
  } state_t;

endpackage

/* rtl/circular_deque.sv */
// circular_deque: push/pop at both ends of a deque kept in a circular store
// push: result strobe in the cycle after accept, busy stays low; pop: word passes the
// store read register (synchronous read), then the result register in S_POP, busy high
// in S_POP; list of n words: first word takes the same path, then one word per cycle,
// busy high in S_LIST (single store read port); empty list or refused request: strobe
// in the cycle after accept; reset (rst_n, synchronous) clears front/rear indices, count,
// control state and the strobe; the store is not cleared; results cannot be stalled by the receiver
module circular_deque #(
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [cdq_pkg::FUNC_W-1:0]             in_func,
  input  logic signed [cdq_pkg::WORD_W-1:0]      in_value,
  output logic                                   out_valid,
  output logic [cdq_pkg::STATUS_W-1:0]           out_status,
  output logic signed [cdq_pkg::WORD_W-1:0]      out_result_value,
  output logic                                   out_last
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // wrap-around index steps
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_LAST : i - IDX_W'(1);
  endfunction

  // control state
  cdq_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] rear_r, rear_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  // listing walk: next address to read and words still to emit
  logic [IDX_W-1:0] lidx_r, lidx_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;

  // result register
  logic                               out_valid_r, out_valid_nxt;
  logic [cdq_pkg::STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic signed [cdq_pkg::WORD_W-1:0]  out_value_r, out_value_nxt;
  logic                               out_last_r, out_last_nxt;

  // store ports: one write, one registered read
  logic signed [cdq_pkg::WORD_W-1:0] store_mem [DEPTH];
  logic                              wr_en;
  logic [IDX_W-1:0]                  wr_addr;
  logic signed [cdq_pkg::WORD_W-1:0] wr_data;
  logic                              rd_en;
  logic [IDX_W-1:0]                  rd_addr;
  logic signed [cdq_pkg::WORD_W-1:0] rd_data_r;

  logic accept;

  assign busy   = (state_r != cdq_pkg::S_IDLE);
  assign accept = start && !busy;

  // a write only happens at a push accept, reads only at a pop or list accept
  // and while listing, so one entry is never written and read in the same
  // cycle; a push followed by a pop sees the new word since the write lands first
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  // next state, store access and result word
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    rear_nxt       = rear_r;
    occ_nxt        = occ_r;
    lidx_nxt       = lidx_r;
    left_nxt       = left_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = cdq_pkg::ST_DONE;
    out_value_nxt  = '0;
    out_last_nxt   = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = front_r;
    wr_data        = in_value;
    rd_en          = 1'b0;
    rd_addr        = front_r;

    unique case (state_r)
      cdq_pkg::S_IDLE: begin
        if (accept) begin
          case (in_func) inside
            cdq_pkg::FUNC_PUSH_FRONT, cdq_pkg::FUNC_PUSH_REAR: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (occ_r == CNT_FULL) begin
                out_status_nxt = cdq_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                occ_nxt = occ_r + CNT_ONE;
                if (occ_r == '0) begin
                  // first word always lands at entry 0
                  front_nxt = '0;
                  rear_nxt  = '0;
                  wr_addr   = '0;
                end else if (in_func == cdq_pkg::FUNC_PUSH_FRONT) begin
                  front_nxt = idx_dec(front_r);
                  wr_addr   = front_nxt;
                end else begin
                  rear_nxt = idx_inc(rear_r);
                  wr_addr  = rear_nxt;
                end
              end
            end
            cdq_pkg::FUNC_POP_FRONT, cdq_pkg::FUNC_POP_REAR: begin
              if (occ_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = cdq_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                occ_nxt   = occ_r - CNT_ONE;
                state_nxt = cdq_pkg::S_POP;
                if (in_func == cdq_pkg::FUNC_POP_FRONT) begin
                  rd_addr = front_r;
                  if (occ_r != CNT_ONE) begin
                    front_nxt = idx_inc(front_r);
                  end
                end else begin
                  rd_addr = rear_r;
                  if (occ_r != CNT_ONE) begin
                    rear_nxt = idx_dec(rear_r);
                  end
                end
              end
            end
            cdq_pkg::FUNC_LIST: begin
              if (occ_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = cdq_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                lidx_nxt  = idx_inc(front_r);
                left_nxt  = occ_r;
                state_nxt = cdq_pkg::S_LIST;
              end
            end
            default: begin
              // unused request codes are dropped without a result
            end
          endcase
        end
      end
      cdq_pkg::S_POP: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        out_value_nxt = rd_data_r;
        state_nxt     = cdq_pkg::S_IDLE;
      end
      cdq_pkg::S_LIST: begin
        // emit the word read last cycle, fetch the next one
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_data_r;
        out_last_nxt  = (left_r == CNT_ONE);
        left_nxt      = left_r - CNT_ONE;
        if (left_r == CNT_ONE) begin
          state_nxt = cdq_pkg::S_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = lidx_r;
          lidx_nxt = idx_inc(lidx_r);
        end
      end
      default: begin
        state_nxt = cdq_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdq_pkg::S_IDLE;
      front_r     <= '0;
      rear_r      <= '0;
      occ_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      occ_r       <= occ_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    lidx_r       <= lidx_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_last         = out_last_r;

  // occupancy never goes past the store depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_FULL)
    else $error("occupancy beyond depth");

  // a push is answered in the very next cycle as a single final word
  a_push_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == cdq_pkg::FUNC_PUSH_FRONT || in_func == cdq_pkg::FUNC_PUSH_REAR))
    |=> (out_valid && out_last))
    else $error("push result missing");

  // every listing cycle delivers a word
  a_list_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cdq_pkg::S_LIST) |=> out_valid)
    else $error("listing word missing");

  // the listing walk never runs with nothing left to emit
  a_list_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cdq_pkg::S_LIST) |-> (left_r != '0 && left_r <= occ_r))
    else $error("listing count out of range");

endmodule
